// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dstw_pkg.sv
// Package: types, codes and constants of the source-chain tag walker.
`timescale 1ns / 1ps
package dstw_pkg;

    localparam int MAX_TAGS = 4096;
    localparam int TAGS_W   = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TAG   = 1'b1;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CHAIN  = 2'd1;

    localparam logic [2:0] KIND_TAG   = 3'd0;
    localparam logic [2:0] KIND_BURST = 3'd1;
    localparam logic [2:0] KIND_FETCH = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;
    localparam logic [2:0] TAG_REFS = 3'd4;
    localparam logic [2:0] TAG_CALL = 3'd5;
    localparam logic [2:0] TAG_RET  = 3'd6;
    localparam logic [2:0] TAG_END  = 3'd7;

    localparam logic [31:0] ADDR_MASK = 32'h7FFF_FFF0;
    localparam logic [31:0] SPR_BASE  = 32'h7000_0000;
    localparam logic [31:0] SPR_MASK  = 32'h0000_3FF0;
    localparam logic [31:0] QW_BYTES  = 32'd16;

    typedef logic [2:0] kind_t;

    typedef struct packed {
        logic        has_tag;
        logic [63:0] tag_words;
        logic        has_burst;
        logic [31:0] burst_address;
        logic [15:0] burst_count;
        kind_t       final_kind;
        logic [31:0] final_address;
        logic [31:0] final_tag_address;
        logic [31:0] final_control;
    } plan_t;

endpackage

// File: rtl/dstw_if.sv
// Request and response channel interfaces of the tag walker.
`timescale 1ns / 1ps
interface dstw_req_if import dstw_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] start_control;
    logic [31:0] start_address;
    logic [15:0] start_count;
    logic [31:0] start_tag_address;
    logic [63:0] tag_lower;
    logic [63:0] tag_upper;
    logic        fetch_fault;

    modport source (output valid, command, start_control, start_address, start_count,
                    start_tag_address, tag_lower, tag_upper, fetch_fault, input ready);
    modport sink (input valid, command, start_control, start_address, start_count,
                  start_tag_address, tag_lower, tag_upper, fetch_fault, output ready);
endinterface

interface dstw_rsp_if import dstw_pkg::*; ();
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [31:0] address;
    logic [15:0] count;
    logic [63:0] tag_words;
    logic [31:0] final_tag_address;
    logic [31:0] final_control;
    logic        last;

    modport source (output valid, kind, address, count, tag_words, final_tag_address,
                    final_control, last, input ready);
    modport sink (input valid, kind, address, count, tag_words, final_tag_address,
                  final_control, last, output ready);
endinterface

// File: rtl/dstw_queue.sv
// Two-entry queue of transaction plans between front and back.
`timescale 1ns / 1ps
module dstw_queue import dstw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  plan_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output plan_t pop_data
);

    plan_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/dstw_front.sv
// Front end: accepts commands and tags, keeps channel state, builds plans.
`timescale 1ns / 1ps
module dstw_front import dstw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dstw_req_if.sink   req,
    output logic       push_valid,
    input  logic       push_ready,
    output plan_t      push_data
);

    logic [31:0]       tag_address_reg, tag_address_next;
    logic [31:0]       control_reg, control_next;
    logic [31:0]       stack0_reg, stack0_next;
    logic [31:0]       stack1_reg, stack1_next;
    logic [TAGS_W-1:0] tags_seen_reg, tags_seen_next;
    logic              active_reg, active_next;

    logic              accept;
    logic [31:0]       tag0;
    logic [31:0]       tag1;
    logic [31:0]       here16;
    logic [31:0]       tag_addr;
    logic [15:0]       qw_count;
    logic [31:0]       qw_bytes;
    logic [31:0]       ret_addr;
    logic [31:0]       mem_addr;
    logic [31:0]       mem_final;
    logic [31:0]       control_tag;
    logic [1:0]        sp;
    logic              chain_end;
    logic [TAGS_W:0]   tags_inc;
    plan_t             plan;

    assign accept     = req.valid && req.ready;
    assign req.ready  = push_ready;
    assign push_valid = accept && ((req.command == CMD_START) || active_reg);
    assign push_data  = plan;

    assign tag0     = req.tag_lower[31:0];
    assign tag1     = req.tag_lower[63:32];
    assign here16   = (tag_address_reg & ADDR_MASK) + QW_BYTES;
    assign tag_addr = tag1[31] ? (SPR_BASE | (tag1 & SPR_MASK)) : (tag1 & ADDR_MASK);
    assign qw_count = (req.command == CMD_START) ? req.start_count : tag0[15:0];
    assign qw_bytes = {12'd0, qw_count, 4'd0};
    assign ret_addr = here16 + qw_bytes;
    assign tags_inc = {1'b0, tags_seen_reg} + {{TAGS_W{1'b0}}, 1'b1};

    always_comb
    begin
        tag_address_next = tag_address_reg;
        control_next     = control_reg;
        stack0_next      = stack0_reg;
        stack1_next      = stack1_reg;
        tags_seen_next   = tags_seen_reg;
        active_next      = active_reg;
        control_tag      = {tag0[31:16], control_reg[15:0]};
        sp               = control_reg[5:4];
        chain_end        = tag0[31] && control_reg[7];
        mem_addr         = here16;
        mem_final        = 32'd0;
        plan             = '0;

        if (req.command == CMD_START)
        begin
            control_next     = req.start_control;
            tag_address_next = req.start_tag_address;
            tags_seen_next   = '0;
            plan.has_burst   = (req.start_count != 16'd0);
            plan.burst_count = req.start_count;
            mem_final        = (req.start_count != 16'd0) ?
                               (req.start_address + qw_bytes) : req.start_address;
            case (req.start_control[3:2])
                MODE_NORMAL:
                begin
                    plan.burst_address     = req.start_address & ADDR_MASK;
                    plan.final_kind        = KIND_DONE;
                    plan.final_address     = mem_final & ADDR_MASK;
                    plan.final_tag_address = req.start_tag_address;
                    plan.final_control     = req.start_control;
                    active_next            = 1'b0;
                end
                MODE_CHAIN:
                begin
                    plan.burst_address = req.start_address;
                    plan.final_kind    = KIND_FETCH;
                    plan.final_address = req.start_tag_address & ADDR_MASK;
                    active_next        = 1'b1;
                end
                default:
                begin
                    plan.has_burst  = 1'b0;
                    plan.final_kind = KIND_ERROR;
                    active_next     = 1'b0;
                end
            endcase
        end
        else if (req.fetch_fault)
        begin
            plan.final_kind = KIND_ERROR;
            active_next     = 1'b0;
        end
        else
        begin
            case (tag0[30:28])
                TAG_REFE:
                begin
                    mem_addr         = tag_addr;
                    tag_address_next = here16;
                    chain_end        = 1'b1;
                end
                TAG_CNT:
                    tag_address_next = ret_addr;
                TAG_NEXT:
                    tag_address_next = tag_addr;
                TAG_REF, TAG_REFS:
                begin
                    mem_addr         = tag_addr;
                    tag_address_next = here16;
                end
                TAG_CALL:
                begin
                    tag_address_next = tag_addr;
                    if (sp == 2'd0)
                    begin
                        stack0_next = ret_addr;
                        sp          = 2'd1;
                    end
                    else if (sp == 2'd1)
                    begin
                        stack1_next = ret_addr;
                        sp          = 2'd2;
                    end
                    else
                        chain_end = 1'b1;
                end
                TAG_RET:
                begin
                    if (sp == 2'd2)
                    begin
                        tag_address_next = stack1_reg;
                        sp               = 2'd1;
                    end
                    else if (sp == 2'd1)
                    begin
                        tag_address_next = stack0_reg;
                        sp               = 2'd0;
                    end
                    else
                        chain_end = 1'b1;
                end
                default:
                    chain_end = 1'b1;
            endcase

            control_next = {control_tag[31:6], sp, control_tag[3:0]};

            plan.has_tag       = control_reg[6];
            plan.tag_words     = req.tag_upper;
            plan.has_burst     = (qw_count != 16'd0);
            plan.burst_address = mem_addr;
            plan.burst_count   = qw_count;
            mem_final          = (qw_count != 16'd0) ? ((mem_addr + qw_bytes) & ADDR_MASK)
                                                     : mem_addr;

            if (tags_inc >= (TAGS_W + 1)'(MAX_TAGS))
                chain_end = 1'b1;
            else
                tags_seen_next = tags_inc[TAGS_W-1:0];

            if (chain_end)
            begin
                plan.final_kind        = KIND_DONE;
                plan.final_address     = mem_final;
                plan.final_tag_address = tag_address_next;
                plan.final_control     = control_next;
                active_next            = 1'b0;
            end
            else
            begin
                plan.final_kind    = KIND_FETCH;
                plan.final_address = tag_address_next & ADDR_MASK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_address_reg <= '0;
            control_reg     <= '0;
            stack0_reg      <= '0;
            stack1_reg      <= '0;
            tags_seen_reg   <= '0;
            active_reg      <= 1'b0;
        end
        else if (push_valid)
        begin
            tag_address_reg <= tag_address_next;
            control_reg     <= control_next;
            stack0_reg      <= stack0_next;
            stack1_reg      <= stack1_next;
            tags_seen_reg   <= tags_seen_next;
            active_reg      <= active_next;
        end
    end

endmodule

// File: rtl/dstw_back.sv
// Back end: expands each plan into tag, burst and closing transactions.
`timescale 1ns / 1ps
module dstw_back import dstw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       plan_valid,
    output logic       plan_pop,
    input  plan_t      plan,
    dstw_rsp_if.source rsp
);

    localparam logic [1:0] PH_TAG   = 2'd0;
    localparam logic [1:0] PH_BURST = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic        valid_reg;
    kind_t       kind_reg, kind_next;
    logic [31:0] address_reg, address_next;
    logic [15:0] count_reg, count_next;
    logic [63:0] words_reg, words_next;
    logic [31:0] fta_reg, fta_next;
    logic [31:0] fc_reg, fc_next;
    logic        last_reg, last_next;
    logic        out_free;
    logic        emit;

    assign out_free = !valid_reg || rsp.ready;
    assign emit     = plan_valid && out_free;
    assign plan_pop = emit && last_next;

    always_comb
    begin
        kind_next    = plan.final_kind;
        address_next = plan.final_address;
        count_next   = 16'd0;
        words_next   = 64'd0;
        fta_next     = plan.final_tag_address;
        fc_next      = plan.final_control;
        last_next    = 1'b1;
        phase_next   = PH_TAG;
        case (phase_reg)
            PH_TAG:
            begin
                if (plan.has_tag)
                begin
                    kind_next    = KIND_TAG;
                    address_next = 32'd0;
                    words_next   = plan.tag_words;
                    fta_next     = 32'd0;
                    fc_next      = 32'd0;
                    last_next    = 1'b0;
                    phase_next   = PH_BURST;
                end
                else if (plan.has_burst)
                begin
                    kind_next    = KIND_BURST;
                    address_next = plan.burst_address;
                    count_next   = plan.burst_count;
                    fta_next     = 32'd0;
                    fc_next      = 32'd0;
                    last_next    = 1'b0;
                    phase_next   = PH_FINAL;
                end
            end
            PH_BURST:
            begin
                if (plan.has_burst)
                begin
                    kind_next    = KIND_BURST;
                    address_next = plan.burst_address;
                    count_next   = plan.burst_count;
                    fta_next     = 32'd0;
                    fc_next      = 32'd0;
                    last_next    = 1'b0;
                    phase_next   = PH_FINAL;
                end
            end
            default:
                phase_next = PH_TAG;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                phase_reg <= phase_next;
            if (out_free)
                valid_reg <= plan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg    <= kind_next;
            address_reg <= address_next;
            count_reg   <= count_next;
            words_reg   <= words_next;
            fta_reg     <= fta_next;
            fc_reg      <= fc_next;
            last_reg    <= last_next;
        end
    end

    assign rsp.valid             = valid_reg;
    assign rsp.kind              = kind_reg;
    assign rsp.address           = address_reg;
    assign rsp.count             = count_reg;
    assign rsp.tag_words         = words_reg;
    assign rsp.final_tag_address = fta_reg;
    assign rsp.final_control     = fc_reg;
    assign rsp.last              = last_reg;

endmodule

// File: rtl/dma_source_chain_tag_walker_core.sv
// Top level of the source-chain DMA tag walker.
// req carries start commands (control, address, count, tag address) and
// fetched tags (lower and upper doubleword, bus fault flag). rsp carries
// the resulting transactions: tag words, payload burst, tag fetch, done or
// error, with last set on the closing one of each request.
// A start in normal mode gives an optional burst and done; in chain mode an
// optional burst and the first tag fetch; in any other mode an error. Each
// tag gives optional tag words, an optional burst, then the next fetch or
// done, or error on a fetch fault; tags taken while idle are dropped.
// A request is decoded in the cycle it is taken; its plan is registered in
// the plan queue, then its first transaction in the rsp output registers.
// Throughput: rsp issues one transaction per cycle while rsp is ready; a
// request produces 1 to 3 transactions, and the two-entry plan queue lets
// req keep being taken while rsp works through earlier ones.
// Reset clears the channel registers and return stack and leaves the
// channel idle with empty queue. A stalled rsp holds its transaction; req
// stays ready until the plan queue fills.
`timescale 1ns / 1ps
module dma_source_chain_tag_walker_core import dstw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dstw_req_if.sink   req,
    dstw_rsp_if.source rsp
);

    logic  push_valid;
    logic  push_ready;
    plan_t push_data;
    logic  head_valid;
    logic  head_pop;
    plan_t head_plan;

    dstw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dstw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_plan)
    );

    dstw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (head_valid),
        .plan_pop   (head_pop),
        .plan       (head_plan),
        .rsp        (rsp)
    );

endmodule

// File: rtl/dstw_checker.sv
// Port-level checks on the response channel of the tag walker.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dstw_checker import dstw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input kind_t       rsp_kind,
    input logic [31:0] rsp_address,
    input logic [15:0] rsp_count,
    input logic [63:0] rsp_tag_words,
    input logic [31:0] rsp_final_tag_address,
    input logic [31:0] rsp_final_control,
    input logic        rsp_last
);

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_address) && $stable(rsp_last), "stalled transaction changed")
    `ASSERT_IMPLY(a_last_closing, clk, rst_n, rsp_valid, rsp_last == ((rsp_kind == KIND_DONE) || (rsp_kind == KIND_FETCH) || (rsp_kind == KIND_ERROR)), "last flag does not match kind")
    `ASSERT_IMPLY(a_error_clear, clk, rst_n, rsp_valid && (rsp_kind == KIND_ERROR), (rsp_address == 32'd0) && (rsp_count == 16'd0) && (rsp_tag_words == 64'd0) && (rsp_final_tag_address == 32'd0) && (rsp_final_control == 32'd0), "error carries payload")
    `ASSERT_IMPLY(a_done_drained, clk, rst_n, rsp_valid && (rsp_kind == KIND_DONE), (rsp_count == 16'd0) && (rsp_tag_words == 64'd0), "done with count left")
    `ASSERT_IMPLY(a_burst_nonzero, clk, rst_n, rsp_valid && (rsp_kind == KIND_BURST), (rsp_count != 16'd0) && (rsp_final_tag_address == 32'd0), "empty payload burst")

endmodule

bind dma_source_chain_tag_walker_core dstw_checker u_dstw_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_kind              (rsp.kind),
    .rsp_address           (rsp.address),
    .rsp_count             (rsp.count),
    .rsp_tag_words         (rsp.tag_words),
    .rsp_final_tag_address (rsp.final_tag_address),
    .rsp_final_control     (rsp.final_control),
    .rsp_last              (rsp.last)
);
